>>> rtl/salc_pkg.sv
package salc_pkg;

   localparam int ADDR_W   = 32;
   localparam int TAG_W    = 32;
   localparam int CNT_W    = 32;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // register index codes, taken from paddr[3:2]
   localparam logic [1:0] REG_BLOCK_SHIFT = 2'd0;
   localparam logic [1:0] REG_SET_SHIFT   = 2'd1;
   localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;
   localparam logic [1:0] REG_LATENCY     = 2'd3;

   typedef struct packed {
      logic [3:0] block_shift;
      logic [2:0] set_shift;
      logic [2:0] ways_in_use;
      logic [7:0] latency;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

>>> rtl/set_assoc_cache_lru_lookup_core.sv
// Tag lookup for a set-associative cache with least-recently-used replacement.
// Input channel req_*: one byte address per transfer. Result channel rsp_*:
// one result per address, in order: hit, way, configured latency and the
// running access and miss counts (both wrap at 32 bits).
// The csr_* port is an APB-style register port: block_shift at 0x0,
// set_shift at 0x4, ways_in_use at 0x8, latency at 0xC. Write it only while
// no address is outstanding.
// A front stage splits the address into set and tag and parks it in a
// two-entry queue; the back stage reads the set row, then compares, picks
// the victim and writes the row back.
// An address passes a queue entry, the row read registers and the result
// register; the back stage takes the next address only after the write-back
// of the last one, as the set-row memories have a single read/write port.
// Reset: counters clear and a clearing pass runs over all valid and stamp
// rows; req_ready stays low until it is done.
// A stalled rsp_ready holds the result; the queue keeps taking addresses
// until both entries are full.
module set_assoc_cache_lru_lookup_core #(
   parameter int SETS = 64,
   parameter int WAYS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [31:0]                  req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [1:0]                   rsp_way,
   output logic [7:0]                   rsp_latency_cycles,
   output logic [31:0]                  rsp_access_count,
   output logic [31:0]                  rsp_miss_count,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [salc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [salc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [salc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

   salc_pkg::cfg_type          cfg;
   logic                       clearing;
   logic                       q_valid;
   logic                       q_pop;
   logic [SET_W-1:0]           q_set;
   logic [salc_pkg::TAG_W-1:0] q_tag;

   salc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   salc_front #(
      .SETS (SETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .cfg         (cfg),
      .hold        (clearing),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_set       (q_set),
      .q_tag       (q_tag)
   );

   salc_back #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_set              (q_set),
      .q_tag              (q_tag),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_way            (rsp_way),
      .rsp_latency_cycles (rsp_latency_cycles),
      .rsp_access_count   (rsp_access_count),
      .rsp_miss_count     (rsp_miss_count)
   );

endmodule

>>> rtl/salc_csr.sv
module salc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [salc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [salc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [salc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output salc_pkg::cfg_type            cfg
);

   salc_pkg::cfg_type cfg_ff;
   salc_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            salc_pkg::REG_BLOCK_SHIFT: cfg_in.block_shift = csr_pwdata[3:0];
            salc_pkg::REG_SET_SHIFT:   cfg_in.set_shift   = csr_pwdata[2:0];
            salc_pkg::REG_WAYS_IN_USE: cfg_in.ways_in_use = csr_pwdata[2:0];
            salc_pkg::REG_LATENCY:     cfg_in.latency     = csr_pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_shift <= 4'd6;
         cfg_ff.set_shift   <= 3'd6;
         cfg_ff.ways_in_use <= 3'd4;
         cfg_ff.latency     <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         salc_pkg::REG_BLOCK_SHIFT: csr_prdata = 32'(cfg_ff.block_shift);
         salc_pkg::REG_SET_SHIFT:   csr_prdata = 32'(cfg_ff.set_shift);
         salc_pkg::REG_WAYS_IN_USE: csr_prdata = 32'(cfg_ff.ways_in_use);
         salc_pkg::REG_LATENCY:     csr_prdata = 32'(cfg_ff.latency);
         default:                   csr_prdata = '0;
      endcase
   end

endmodule

>>> rtl/salc_front.sv
module salc_front #(
   parameter int SETS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [salc_pkg::ADDR_W-1:0]        req_address,
   input  salc_pkg::cfg_type                  cfg,
   input  logic                               hold,
   output logic                               q_valid,
   input  logic                               q_pop,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] q_set,
   output logic [salc_pkg::TAG_W-1:0]         q_tag
);

   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int SS_MAX = $clog2(SETS + 1) - 1;

   logic [3:0]                 ss_eff;
   logic [salc_pkg::ADDR_W-1:0] blk;
   logic [salc_pkg::ADDR_W-1:0] set_mask;
   logic [SET_W-1:0]           set_idx;
   logic [salc_pkg::TAG_W-1:0] tag;
   logic                       push;

   logic [SET_W-1:0]           ent_set_ff [2];
   logic [salc_pkg::TAG_W-1:0] ent_tag_ff [2];
   logic                       wr_ptr_ff;
   logic                       wr_ptr_in;
   logic                       rd_ptr_ff;
   logic                       rd_ptr_in;
   logic [1:0]                 count_ff;
   logic [1:0]                 count_in;

   // clamp set_shift so that the sets in use fit the array
   always_comb begin
      ss_eff   = ({1'b0, cfg.set_shift} > 4'(SS_MAX)) ? 4'(SS_MAX) : {1'b0, cfg.set_shift};
      blk      = req_address >> cfg.block_shift;
      set_mask = (32'd1 << ss_eff) - 32'd1;
      set_idx  = SET_W'(blk & set_mask);
      tag      = blk >> ss_eff;
   end

   assign req_ready = (count_ff != 2'd2) && !hold;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_set     = ent_set_ff[rd_ptr_ff];
   assign q_tag     = ent_tag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_set_ff[wr_ptr_ff] <= set_idx;
         ent_tag_ff[wr_ptr_ff] <= tag;
      end
   end

endmodule

>>> rtl/salc_back.sv
module salc_back #(
   parameter int SETS = 64,
   parameter int WAYS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  salc_pkg::cfg_type                  cfg,
   input  logic                               q_valid,
   output logic                               q_pop,
   input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] q_set,
   input  logic [salc_pkg::TAG_W-1:0]         q_tag,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [1:0]                         rsp_way,
   output logic [7:0]                         rsp_latency_cycles,
   output logic [salc_pkg::CNT_W-1:0]         rsp_access_count,
   output logic [salc_pkg::CNT_W-1:0]         rsp_miss_count
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   // set rows: valid and stamp are cleared after reset, tags are not
   logic [WAYS-1:0]                          valid_mem [SETS];
   logic [WAYS-1:0][salc_pkg::CNT_W-1:0]     stamp_mem [SETS];
   logic [WAYS-1:0][salc_pkg::TAG_W-1:0]     tag_mem   [SETS];

   logic [WAYS-1:0]                          valid_rd_ff;
   logic [WAYS-1:0][salc_pkg::CNT_W-1:0]     stamp_rd_ff;
   logic [WAYS-1:0][salc_pkg::TAG_W-1:0]     tag_rd_ff;

   salc_pkg::state_type                      state_ff;
   salc_pkg::state_type                      state_in;
   logic [SET_W-1:0]                         clr_cnt_ff;
   logic [SET_W-1:0]                         clr_cnt_in;
   logic [SET_W-1:0]                         cur_set_ff;
   logic [salc_pkg::TAG_W-1:0]               cur_tag_ff;
   logic [salc_pkg::CNT_W-1:0]               access_cnt_ff;
   logic [salc_pkg::CNT_W-1:0]               access_cnt_in;
   logic [salc_pkg::CNT_W-1:0]               miss_cnt_ff;
   logic [salc_pkg::CNT_W-1:0]               miss_cnt_in;
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic                                     rsp_hit_ff;
   logic [1:0]                               rsp_way_ff;
   logic [7:0]                               rsp_latency_ff;

   logic                                     out_free;
   logic                                     upd_fire;
   logic                                     mem_we;
   logic [SET_W-1:0]                         mem_waddr;
   logic [WAYS-1:0]                          valid_wdata;
   logic [WAYS-1:0][salc_pkg::CNT_W-1:0]     stamp_wdata;
   logic [salc_pkg::CNT_W-1:0]               stamp_new;

   logic [4:0]                               wiu;
   logic [4:0]                               nways;
   logic                                     hit;
   logic [WAY_W-1:0]                         hit_way;
   logic                                     any_free;
   logic [WAY_W-1:0]                         free_way;
   logic [WAY_W-1:0]                         lru_way;
   logic [salc_pkg::CNT_W-1:0]               best;
   logic [WAY_W-1:0]                         pick;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stamp_new = access_cnt_ff + 32'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salc_pkg::ST_CLEAR:  if (clr_cnt_ff == SET_W'(SETS - 1)) state_in = salc_pkg::ST_IDLE;
         salc_pkg::ST_IDLE:   if (q_valid) state_in = salc_pkg::ST_UPDATE;
         salc_pkg::ST_UPDATE: if (out_free) state_in = salc_pkg::ST_IDLE;
         default:             state_in = salc_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop    = 1'b0;
      upd_fire = 1'b0;
      clearing = 1'b0;
      case (state_ff)
         salc_pkg::ST_CLEAR:  clearing = 1'b1;
         salc_pkg::ST_IDLE:   q_pop    = q_valid;
         salc_pkg::ST_UPDATE: upd_fire = out_free;
         default:             clearing = 1'b0;
      endcase
   end

   // way search, free way and least recently used way over the row
   always_comb begin
      wiu   = 5'(cfg.ways_in_use);
      nways = (wiu == 5'd0) ? 5'd1 : ((wiu > 5'(WAYS)) ? 5'(WAYS) : wiu);
      hit      = 1'b0;
      hit_way  = '0;
      any_free = 1'b0;
      free_way = '0;
      lru_way  = '0;
      best     = stamp_rd_ff[0];
      for (int w = 0; w < WAYS; w++) begin
         if (5'(w) < nways) begin
            if (!hit && valid_rd_ff[w] && (tag_rd_ff[w] == cur_tag_ff)) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
            end
            if (!any_free && !valid_rd_ff[w]) begin
               any_free = 1'b1;
               free_way = WAY_W'(w);
            end
            if ((w > 0) && (stamp_rd_ff[w] < best)) begin
               best    = stamp_rd_ff[w];
               lru_way = WAY_W'(w);
            end
         end
      end
      pick = hit ? hit_way : (any_free ? free_way : lru_way);
   end

   always_comb begin
      mem_we    = clearing || upd_fire;
      mem_waddr = clearing ? clr_cnt_ff : cur_set_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (clearing) begin
            valid_wdata[w] = 1'b0;
            stamp_wdata[w] = '0;
         end else begin
            valid_wdata[w] = valid_rd_ff[w] || (WAY_W'(w) == pick);
            stamp_wdata[w] = (WAY_W'(w) == pick) ? stamp_new : stamp_rd_ff[w];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         valid_mem[mem_waddr] <= valid_wdata;
         stamp_mem[mem_waddr] <= stamp_wdata;
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < WAYS; w++) begin
         if (upd_fire && !hit && (WAY_W'(w) == pick)) begin
            tag_mem[cur_set_ff][w] <= cur_tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         valid_rd_ff <= valid_mem[q_set];
         stamp_rd_ff <= stamp_mem[q_set];
         tag_rd_ff   <= tag_mem[q_set];
         cur_set_ff  <= q_set;
         cur_tag_ff  <= q_tag;
      end
   end

   always_comb begin
      clr_cnt_in    = clearing ? (clr_cnt_ff + SET_W'(1)) : clr_cnt_ff;
      access_cnt_in = upd_fire ? stamp_new : access_cnt_ff;
      miss_cnt_in   = (upd_fire && !hit) ? (miss_cnt_ff + 32'd1) : miss_cnt_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= salc_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         access_cnt_ff <= '0;
         miss_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         access_cnt_ff <= access_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_hit_ff     <= hit;
         rsp_way_ff     <= 2'(pick);
         rsp_latency_ff <= cfg.latency;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_way            = rsp_way_ff;
   assign rsp_latency_cycles = rsp_latency_ff;
   assign rsp_access_count   = access_cnt_ff;
   assign rsp_miss_count     = miss_cnt_ff;

   a_access_step: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> (access_cnt_ff == $past(access_cnt_ff) + 32'd1))
      else $error("access count did not advance by one on update");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      upd_fire |-> (5'(pick) < nways))
      else $error("picked way outside the ways in use");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == salc_pkg::ST_UPDATE))
      else $error("result raised outside the update step");

   a_miss_with_access: assert property (@(posedge clock) disable iff (reset)
      (miss_cnt_ff != $past(miss_cnt_ff)) |-> (access_cnt_ff != $past(access_cnt_ff)))
      else $error("miss counted without an access");

endmodule

>>> verif/lru_lookup_checker.sv
module lru_lookup_checker #(
   parameter int SETS = 64,
   parameter int WAYS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [31:0]                   req_address,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_hit,
   input  logic [1:0]                    rsp_way,
   input  logic [7:0]                    rsp_latency_cycles,
   input  logic [31:0]                   rsp_access_count,
   input  logic [31:0]                   rsp_miss_count,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [salc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [salc_pkg::CSR_DW-1:0]   csr_pwdata,
   output int                            failures,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 200;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic [7:0]  latency_cycles;
      logic [31:0] access_count;
      logic [31:0] miss_count;
   } lookup_result_type;

   salc_pkg::cfg_type cfg;
   logic              way_valid [SETS][WAYS];
   logic [31:0]       way_tag   [SETS][WAYS];
   logic [31:0]       way_stamp [SETS][WAYS];
   logic [31:0]       accesses;
   logic [31:0]       misses;
   lookup_result_type expected_lookups [$];

   assign pending = expected_lookups.size();

   function automatic lookup_result_type predict_lookup(input logic [31:0] addr);
      int unsigned       ss;
      int unsigned       nways;
      int unsigned       set_idx;
      int unsigned       pick;
      logic [31:0]       blk;
      logic [31:0]       tag_bits;
      logic [31:0]       oldest;
      bit                found;
      lookup_result_type r;
      ss = 32'(cfg.set_shift);
      while (ss > 0 && (1 << ss) > SETS) ss--;
      nways = 32'(cfg.ways_in_use);
      if (nways < 1) nways = 1;
      if (nways > WAYS) nways = WAYS;
      accesses = accesses + 32'd1;
      blk      = addr >> cfg.block_shift;
      set_idx  = blk & ((32'd1 << ss) - 32'd1);
      tag_bits = blk >> ss;
      if (set_idx >= SETS) set_idx = 0;
      found = 1'b0;
      pick  = 0;
      for (int w = 0; w < nways; w++) begin
         if (!found && way_valid[set_idx][w] && way_tag[set_idx][w] == tag_bits) begin
            found = 1'b1;
            pick  = w;
         end
      end
      if (!found) begin
         misses = misses + 32'd1;
         // first free way, else the oldest stamp with the lowest way on ties
         pick = nways;
         for (int w = nways - 1; w >= 0; w--) begin
            if (!way_valid[set_idx][w]) pick = w;
         end
         if (pick == nways) begin
            pick   = 0;
            oldest = way_stamp[set_idx][0];
            for (int w = 1; w < nways; w++) begin
               if (way_stamp[set_idx][w] < oldest) begin
                  oldest = way_stamp[set_idx][w];
                  pick   = w;
               end
            end
         end
         way_valid[set_idx][pick] = 1'b1;
         way_tag[set_idx][pick]   = tag_bits;
      end
      way_stamp[set_idx][pick] = accesses;
      r.hit            = found;
      r.way            = pick[1:0];
      r.latency_cycles = cfg.latency;
      r.access_count   = accesses;
      r.miss_count     = misses;
      return r;
   endfunction

   function automatic void report(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (failures < MAX_REPORTS)
         $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         cfg.block_shift <= 4'd6;
         cfg.set_shift   <= 3'd6;
         cfg.ways_in_use <= 3'd4;
         cfg.latency     <= 8'd1;
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               way_valid[s][w] = 1'b0;
               way_tag[s][w]   = '0;
               way_stamp[s][w] = '0;
            end
         end
         accesses = '0;
         misses   = '0;
         expected_lookups.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               if (failures < MAX_REPORTS) $error("result transfer with no lookup pending");
               failures++;
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_hit !== want.hit) report("hit", 32'(want.hit), 32'(rsp_hit));
               if (rsp_way !== want.way) report("way", 32'(want.way), 32'(rsp_way));
               if (rsp_latency_cycles !== want.latency_cycles)
                  report("latency_cycles", 32'(want.latency_cycles),
                         32'(rsp_latency_cycles));
               if (rsp_access_count !== want.access_count)
                  report("access_count", want.access_count, rsp_access_count);
               if (rsp_miss_count !== want.miss_count)
                  report("miss_count", want.miss_count, rsp_miss_count);
            end
         end
         if (req_valid && req_ready)
            expected_lookups.push_back(predict_lookup(req_address));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               salc_pkg::REG_BLOCK_SHIFT: cfg.block_shift <= csr_pwdata[3:0];
               salc_pkg::REG_SET_SHIFT:   cfg.set_shift   <= csr_pwdata[2:0];
               salc_pkg::REG_WAYS_IN_USE: cfg.ways_in_use <= csr_pwdata[2:0];
               salc_pkg::REG_LATENCY:     cfg.latency     <= csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETS        = 64;
   localparam int WAYS        = 4;
   localparam int STALL_LIMIT = 5000;
   localparam int RAND_PHASES = 10;
   localparam int POOL_SIZE   = 6;

   typedef enum {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_style_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [31:0]                   req_address = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_hit;
   logic [1:0]                    rsp_way;
   logic [7:0]                    rsp_latency_cycles;
   logic [31:0]                   rsp_access_count;
   logic [31:0]                   rsp_miss_count;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [salc_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [salc_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [salc_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   int                            failures;
   int                            pending;
   int                            stall_cycles = 0;
   int                            rsp_hold = 0;
   idle_style_type                send_style = IDLE_RANDOM;
   idle_style_type                rsp_style = IDLE_RANDOM;
   int unsigned                   cur_block_shift = 6;
   int unsigned                   cur_set_shift = 6;
   logic [31:0]                   tag_pool [POOL_SIZE];

   set_assoc_cache_lru_lookup_core #(.SETS(SETS), .WAYS(WAYS)) uut (.*);

   lru_lookup_checker #(.SETS(SETS), .WAYS(WAYS)) u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_address,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_way, .rsp_latency_cycles,
      .rsp_access_count, .rsp_miss_count,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .failures, .pending
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // end the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int draw_gap(input idle_style_type style);
      case (style)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
         default:     return $urandom_range(0, 13);
      endcase
   endfunction

   function automatic idle_style_type pick_style();
      case ($urandom_range(0, 3))
         0:       return IDLE_NONE;
         1:       return IDLE_SPARSE;
         default: return IDLE_RANDOM;
      endcase
   endfunction

   // mostly addresses built from a small tag pool over a few sets so that
   // hits, fills and evictions all happen; the rest is plain noise
   function automatic logic [31:0] make_address();
      int unsigned ss;
      int unsigned pick;
      logic [63:0] blk;
      logic [63:0] set_bits;
      pick = $urandom_range(0, 99);
      if (pick < 12) return $urandom();
      ss = (cur_set_shift > 6) ? 6 : cur_set_shift;
      set_bits = (pick < 70) ? 64'($urandom_range(0, 1)) : 64'($urandom_range(0, SETS - 1));
      set_bits = set_bits & ((64'd1 << ss) - 64'd1);
      blk = (64'(tag_pool[$urandom_range(0, POOL_SIZE - 1)]) << ss) | set_bits;
      return 32'((blk << cur_block_shift) |
                 (64'($urandom()) & ((64'd1 << cur_block_shift) - 64'd1)));
   endfunction

   task automatic send_address(input logic [31:0] addr);
      int gap;
      gap = draw_gap(send_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until the last transfer is counted, then until no lookup is pending
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic write_config(input int unsigned bs, input int unsigned ss,
                               input int unsigned nw, input int unsigned lat);
      drain();
      repeat (4) @(posedge clock);
      write_reg(salc_pkg::REG_BLOCK_SHIFT, ($urandom() & ~32'hF)  | bs);
      write_reg(salc_pkg::REG_SET_SHIFT,   ($urandom() & ~32'h7)  | ss);
      write_reg(salc_pkg::REG_WAYS_IN_USE, ($urandom() & ~32'h7)  | nw);
      write_reg(salc_pkg::REG_LATENCY,     ($urandom() & ~32'hFF) | lat);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_block_shift = bs;
      cur_set_shift   = ss;
   endtask

   // result side: per-result gap, plus a long hold-off when asked
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         gap = draw_gap(rsp_style);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [31:0] directed [$];
      int unsigned items;
      @(negedge reset);
      @(posedge clock);

      // default split: tag in bits 31..12, set in bits 11..6
      directed = '{32'h0000_0000, 32'h0000_003F, 32'h0000_1000, 32'h0000_2000,
                   32'h0000_3000, 32'h0000_0010, 32'h0000_4000, 32'h0000_1000,
                   32'h0000_2000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0040, 32'h8000_0000};
      foreach (directed[i]) send_address(directed[i]);

      // extreme splits, including clamped set and way counts
      write_config(0, 0, 0, 0);
      send_address(32'h0000_0000);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_0000);
      write_config(15, 7, 7, 255);
      send_address(32'h0000_0000);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFC0_0000);
      send_address(32'h0000_8000);

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0:       write_config(12, 6, 4, 255);
            1:       write_config(0, 7, 1, 0);
            2:       write_config(4, 2, 0, 17);
            3:       write_config(2, 3, 7, 200);
            default: write_config($urandom_range(0, 15), $urandom_range(0, 7),
                                  $urandom_range(0, 7), $urandom_range(0, 255));
         endcase
         foreach (tag_pool[i]) tag_pool[i] = $urandom_range(0, 1) ? i : $urandom();
         send_style = (phase == 6) ? IDLE_NONE : pick_style();
         rsp_style  = (phase == 6) ? IDLE_NONE : pick_style();
         items = $urandom_range(100, 115);
         for (int n = 0; n < items; n++) begin
            if (phase == 2 && n == 20) rsp_hold = 300;
            if (phase == 5 && n == 50) drain();
            send_address(make_address());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
